// ===== rtl/sps_pkg.sv =====
// Shared types, constants and helper functions for the pan/tilt stepper sequencer.
`default_nettype none

package sps_pkg;

  // Width of the remaining-steps counter and of the tick divider.
  localparam int unsigned STEP_BITS = 16;
  localparam int unsigned TICK_BITS = 16;

  // Fixed field widths of the item ports.
  localparam int unsigned OP_W    = 3;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned COIL_W  = 4;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned PHASES  = 8;
  localparam int unsigned PHASE_W = $clog2(PHASES);

  // Input operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 3'd0,
    OP_UP    = 3'd1,
    OP_DOWN  = 3'd2,
    OP_LEFT  = 3'd3,
    OP_RIGHT = 3'd4,
    OP_STOP  = 3'd5,
    OP_QUERY = 3'd6,
    OP_DEBUG = 3'd7
  } op_e;

  // Result codes.
  localparam logic [CODE_W-1:0] RES_OK          = 2'd0;
  localparam logic [CODE_W-1:0] RES_MOVE_REJECT = 2'd1;
  localparam logic [CODE_W-1:0] RES_STOP_BUSY   = 2'd2;

  // Mode codes as they appear on the result port.
  localparam logic [MODE_W-1:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_FWD_H    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_BACK_H   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_FWD_V    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_BACK_V   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_STOPPING = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_DONE     = 3'd6;

  // Sequencer mode, one-hot.
  typedef enum logic [6:0] {
    MODE_IDLE     = 7'b0000001,
    MODE_FWD_H    = 7'b0000010,
    MODE_BACK_H   = 7'b0000100,
    MODE_FWD_V    = 7'b0001000,
    MODE_BACK_V   = 7'b0010000,
    MODE_STOPPING = 7'b0100000,
    MODE_DONE     = 7'b1000000
  } mode_e;

  // Half-step coil patterns, forward and reverse.
  localparam logic [COIL_W-1:0] PAT_FWD [PHASES] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hc, 4'h8, 4'h9
  };
  localparam logic [COIL_W-1:0] PAT_BACK [PHASES] = '{
    4'h1, 4'h9, 4'h8, 4'hc, 4'h4, 4'h6, 4'h2, 4'h3
  };

  // Architectural state of the sequencer.
  typedef struct packed {
    mode_e                mode;
    logic [STEP_BITS-1:0] steps;
    logic [PHASE_W-1:0]   phase;
    logic [TICK_BITS-1:0] ticks;
    logic                 stop_req;
    logic [COIL_W-1:0]    coil_h;
    logic [COIL_W-1:0]    coil_v;
  } sps_state_t;

  // One result item.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [VALUE_W-1:0] value;
    logic [COIL_W-1:0]  coil_h;
    logic [COIL_W-1:0]  coil_v;
    logic [MODE_W-1:0]  mode;
  } sps_result_t;

  // Map the one-hot mode onto its port code.
  function automatic logic [MODE_W-1:0] mode_code(input mode_e m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:     c = MODE_CODE_IDLE;
      MODE_FWD_H:    c = MODE_CODE_FWD_H;
      MODE_BACK_H:   c = MODE_CODE_BACK_H;
      MODE_FWD_V:    c = MODE_CODE_FWD_V;
      MODE_BACK_V:   c = MODE_CODE_BACK_V;
      MODE_STOPPING: c = MODE_CODE_STOPPING;
      MODE_DONE:     c = MODE_CODE_DONE;
      default:       c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

  // True in the four moving modes.
  function automatic logic is_moving(input mode_e m);
    return (m == MODE_FWD_H) || (m == MODE_BACK_H) ||
           (m == MODE_FWD_V) || (m == MODE_BACK_V);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sps_machine.sv =====
// Mode machine: one action of the sequencer on a divider expiry.
`default_nettype none

module sps_machine (
  input  sps_pkg::sps_state_t cur_i,
  output sps_pkg::sps_state_t nxt_o
);
  import sps_pkg::*;

  logic              vertical;
  logic              reverse;
  logic [COIL_W-1:0] pattern;
  sps_state_t        drv;

  assign vertical = (cur_i.mode == MODE_FWD_V) || (cur_i.mode == MODE_BACK_V);
  assign reverse  = (cur_i.mode == MODE_BACK_H) || (cur_i.mode == MODE_BACK_V);
  assign pattern  = reverse ? PAT_BACK[cur_i.phase] : PAT_FWD[cur_i.phase];

  // Drive the next half-step pattern and count a full step on phase wrap.
  always_comb begin
    drv = cur_i;
    if (cur_i.steps != '0) begin
      if (vertical) begin
        drv.coil_v = pattern;
      end else begin
        drv.coil_h = pattern;
      end
      if (cur_i.phase == PHASE_W'(PHASES - 1)) begin
        drv.phase = '0;
        drv.steps = cur_i.steps - 1'b1;
        if (cur_i.stop_req) begin
          drv.mode = MODE_STOPPING;
        end
      end else begin
        drv.phase = cur_i.phase + 1'b1;
      end
      // Vertical moves end in the same action that empties the count.
      if (vertical && (drv.steps == '0)) begin
        drv.mode = MODE_STOPPING;
      end
    end else begin
      drv.mode = MODE_STOPPING;
    end
  end

  // Select the action for the present mode.
  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.mode)
      MODE_FWD_H, MODE_BACK_H, MODE_FWD_V, MODE_BACK_V: begin
        nxt_o = drv;
      end
      MODE_STOPPING: begin
        nxt_o.mode = MODE_DONE;
      end
      MODE_DONE: begin
        nxt_o.coil_h   = '0;
        nxt_o.coil_v   = '0;
        nxt_o.stop_req = 1'b0;
        nxt_o.mode     = MODE_IDLE;
      end
      MODE_IDLE: begin
        nxt_o = cur_i;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sps_exec.sv =====
// Item execution: decodes one input item into the next state and its result.
`default_nettype none

module sps_exec (
  input  sps_pkg::sps_state_t           cur_i,
  input  logic [sps_pkg::TICK_BITS-1:0] period_i,
  input  logic [sps_pkg::OP_W-1:0]      op_i,
  input  logic [sps_pkg::COUNT_W-1:0]   count_i,
  output sps_pkg::sps_state_t           nxt_o,
  output sps_pkg::sps_result_t          res_o
);
  import sps_pkg::*;

  op_e                  op;
  sps_state_t           run;
  sps_state_t           tick_st;
  logic [CODE_W-1:0]    code;
  logic                 have_value;
  logic [STEP_BITS-1:0] held_value;
  logic [STEP_BITS-1:0] value;

  assign op = op_e'(op_i);

  sps_machine u_machine (
    .cur_i (cur_i),
    .nxt_o (run)
  );

  // Tick: run the machine on divider expiry, then advance the saturating divider.
  always_comb begin
    tick_st = cur_i;
    if (cur_i.ticks >= period_i) begin
      tick_st       = run;
      tick_st.ticks = '0;
    end
    if (tick_st.ticks != '1) begin
      tick_st.ticks = tick_st.ticks + 1'b1;
    end
  end

  // Command decode.
  always_comb begin
    nxt_o      = cur_i;
    code       = RES_OK;
    have_value = 1'b0;
    held_value = cur_i.steps;
    unique case (op)
      OP_TICK: begin
        nxt_o = tick_st;
      end
      OP_UP, OP_DOWN, OP_LEFT, OP_RIGHT: begin
        if ((cur_i.steps == '0) && (cur_i.mode == MODE_IDLE)) begin
          nxt_o.steps = STEP_BITS'(count_i);
          unique case (op)
            OP_UP:   nxt_o.mode = MODE_FWD_V;
            OP_DOWN: nxt_o.mode = MODE_BACK_V;
            OP_LEFT: nxt_o.mode = MODE_FWD_H;
            default: nxt_o.mode = MODE_BACK_H;
          endcase
        end else begin
          code = RES_MOVE_REJECT;
        end
      end
      OP_STOP: begin
        if (is_moving(cur_i.mode)) begin
          nxt_o.stop_req = 1'b1;
          code           = RES_STOP_BUSY;
        end else if (cur_i.mode == MODE_IDLE) begin
          have_value  = 1'b1;
          nxt_o.steps = '0;
        end else begin
          code = RES_STOP_BUSY;
        end
      end
      OP_QUERY: begin
        nxt_o = cur_i;
      end
      OP_DEBUG: begin
        nxt_o.coil_h = '1;
        nxt_o.coil_v = '1;
      end
      default: begin
        nxt_o = cur_i;
      end
    endcase
  end

  // Assemble the result from the state after the item; a stop in idle reports the steps held before it.
  assign value        = have_value ? held_value : nxt_o.steps;
  assign res_o.code   = code;
  assign res_o.value  = VALUE_W'(value);
  assign res_o.coil_h = nxt_o.coil_h;
  assign res_o.coil_v = nxt_o.coil_v;
  assign res_o.mode   = mode_code(nxt_o.mode);

endmodule

`default_nettype wire

// ===== rtl/stepper_pan_tilt_sequencer_core.sv =====
// Top level of the two-axis pan/tilt stepper sequencer.
//
//   Channel   Direction  Handshake                  Payload
//   config    in         cfg_we_i                   cfg_wdata_i (tick_period)
//   input     in         in_valid_i / in_stall_o    op_i, step_count_i
//   output    out        out_valid_o / out_stall_i  result_code_o, step_value_o,
//                                                   coil_horizontal_o,
//                                                   coil_vertical_o, mode_o
//
// Each item is executed in the cycle of its transfer and its result is shown
// from the result register on the next cycle; one item is taken per clock unless stalled.
// The input stalls only while the result register is full and the output stalls.
// Reset is asynchronous and clears all state, the tick period and the result valid.
`default_nettype none

module stepper_pan_tilt_sequencer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sps_pkg::TICK_BITS-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sps_pkg::OP_W-1:0]     op_i,
  input  logic [sps_pkg::COUNT_W-1:0]  step_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [sps_pkg::CODE_W-1:0]   result_code_o,
  output logic [sps_pkg::VALUE_W-1:0]  step_value_o,
  output logic [sps_pkg::COIL_W-1:0]   coil_horizontal_o,
  output logic [sps_pkg::COIL_W-1:0]   coil_vertical_o,
  output logic [sps_pkg::MODE_W-1:0]   mode_o
);
  import sps_pkg::*;

  sps_state_t           state_q, state_d;
  logic [TICK_BITS-1:0] period_q;
  sps_result_t          res_q, res_d;
  logic                 out_valid_q;
  logic                 in_xfer;

  // The result register frees up when it is empty or being drained.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  sps_exec u_exec (
    .cur_i    (state_q),
    .period_i (period_q),
    .op_i     (op_i),
    .count_i  (step_count_i),
    .nxt_o    (state_d),
    .res_o    (res_d)
  );

  // Tick period register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  // Sequencer state updates on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{mode: MODE_IDLE, default: '0};
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_code_o     = res_q.code;
  assign step_value_o      = res_q.value;
  assign coil_horizontal_o = res_q.coil_h;
  assign coil_vertical_o   = res_q.coil_v;
  assign mode_o            = res_q.mode;

  // An accepted item always leaves a result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("result missing after input transfer");

  // State moves only on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(state_q))
    else $error("state changed without an input transfer");

  // A pending stop request never survives into idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stop_req |-> (state_q.mode != MODE_IDLE))
    else $error("stop request left pending in idle");

  // A step is only ever partly driven while moving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.phase != '0) |-> is_moving(state_q.mode))
    else $error("phase left mid-step outside a moving mode");

endmodule

`default_nettype wire
